>>> rtl/sfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_pkg: shared types and codes for the searchable FIFO queue
// Beat structs for both channels, command and status codes, defaults and
// the control bundle that the queue controller drives into every cell.
// ----------------------------------------------------------------------------
package sfq_pkg;

  // Defaults for the top-level parameters.
  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;

  // Command codes.
  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [1:0] CMD_SEARCH  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // One request beat.
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] value;
  } sfq_req_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data_out;
    logic [6:0]  position;
    logic [6:0]  occupancy;
  } sfq_res_t;

  // Control common to all cells of the chain.
  typedef struct packed {
    logic shift;    // dequeue: every cell takes its neighbor's word
    logic capture;  // search: every cell compares its word with the key
    logic scan;     // search scan: match flags move one cell toward the head
  } sfq_cell_ctrl_t;

endpackage

>>> rtl/sfq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfq_cell: one storage cell of the queue chain
// Holds one data word and one match flag. Words move toward the head on a
// dequeue, match flags move toward the head while a search is scanned.
// ----------------------------------------------------------------------------
module sfq_cell
  import sfq_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sfq_cell_ctrl_t        ctrl,
  input  logic                  load,
  input  logic                  occupied,
  input  logic [DATA_WIDTH-1:0] key,
  input  logic [DATA_WIDTH-1:0] word_in,
  input  logic                  hit_in,
  output logic [DATA_WIDTH-1:0] word,
  output logic                  hit
);

  // Data word: written at the tail on enqueue, taken from the neighbor on dequeue.
  always_ff @(posedge clk) begin
    if (load) begin
      word <= key;
    end else if (ctrl.shift) begin
      word <= word_in;
    end
  end

  // Match flag: set by the compare, then handed toward the head one cell a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctrl.capture) begin
      hit <= occupied && (word == key);
    end else if (ctrl.scan) begin
      hit <= hit_in;
    end
  end

endmodule

>>> rtl/searchable_fifo_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// searchable_fifo_queue_top: FIFO in a chain of cells with linear search
// Head at cell 0. Enqueue appends at the tail, dequeue returns the head and
// moves all words forward, search reports the first matching position.
//
//   channel   handshake        payload
//   request   start / busy     req    (command, value)
//   result    done (strobe)    result (status, data_out, position, occupancy)
//
// Enqueue, dequeue and unused codes are answered from idle; done rises the
// cycle after the request beat. A search compares all cells at once, then
// its match flags shift one cell a cycle toward the head, and it holds busy
// until the first match reaches the head or every occupied cell is scanned.
// Reset empties the queue at once and leaves the stored words undefined.
// The receiver cannot stall: every result beat is final.
// ----------------------------------------------------------------------------
module searchable_fifo_queue_top
  import sfq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  sfq_req_t req,
  output logic     done,
  output sfq_res_t result
);

  localparam int CW = $clog2(DEPTH + 1);

  // Controller states.
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic                  state;
  logic                  state_next;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [CW-1:0]         idx;
  logic [CW-1:0]         idx_next;
  logic                  done_next;
  sfq_res_t              result_next;

  logic                  accept;
  logic [63:0]           value_ext;
  logic [DATA_WIDTH-1:0] key;
  logic                  is_full;
  logic                  is_empty;
  logic                  do_enq;
  logic                  do_deq;
  sfq_cell_ctrl_t        ctrl;

  logic [DATA_WIDTH-1:0] cell_word [DEPTH];
  logic                  cell_hit  [DEPTH];

  assign busy      = (state == S_SCAN);
  assign accept    = start && !busy;
  assign value_ext = 64'(req.value);
  assign key       = value_ext[DATA_WIDTH-1:0];
  assign is_full   = (count == CW'(DEPTH));
  assign is_empty  = (count == '0);
  assign do_enq    = accept && (req.command == CMD_ENQUEUE) && !is_full;
  assign do_deq    = accept && (req.command == CMD_DEQUEUE) && !is_empty;

  // Chain control.
  always_comb begin
    ctrl.shift   = do_deq;
    ctrl.capture = accept && (req.command == CMD_SEARCH);
    ctrl.scan    = (state == S_SCAN);
  end

  // Row of cells; the cell past the tail feeds zeros.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] nb_word;
    logic                  nb_hit;
    if (i == DEPTH - 1) begin : g_last
      assign nb_word = '0;
      assign nb_hit  = 1'b0;
    end else begin : g_mid
      assign nb_word = cell_word[i+1];
      assign nb_hit  = cell_hit[i+1];
    end
    sfq_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .load    (do_enq && (count == CW'(i))),
      .occupied(CW'(i) < count),
      .key     (key),
      .word_in (nb_word),
      .hit_in  (nb_hit),
      .word    (cell_word[i]),
      .hit     (cell_hit[i])
    );
  end

  // Controller: enqueue, dequeue and unused codes answered from idle, search scan in its own state.
  always_comb begin
    state_next  = state;
    count_next  = count;
    idx_next    = idx;
    done_next   = 1'b0;
    result_next = result;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (accept) begin
          result_next.status    = ST_OK;
          result_next.data_out  = '0;
          result_next.position  = '0;
          result_next.occupancy = 7'(count);
          case (req.command)
            CMD_ENQUEUE: begin
              done_next = 1'b1;
              if (is_full) begin
                result_next.status = ST_FULL;
              end else begin
                count_next            = count + 1'b1;
                result_next.occupancy = 7'(count + 1'b1);
              end
            end
            CMD_DEQUEUE: begin
              done_next = 1'b1;
              if (is_empty) begin
                result_next.status = ST_EMPTY;
              end else begin
                count_next            = count - 1'b1;
                result_next.data_out  = 32'(cell_word[0]);
                result_next.occupancy = 7'(count - 1'b1);
              end
            end
            CMD_SEARCH: begin
              state_next = S_SCAN;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        result_next.data_out  = '0;
        result_next.occupancy = 7'(count);
        if (idx == count) begin
          state_next           = S_IDLE;
          done_next            = 1'b1;
          result_next.status   = ST_NOT_FOUND;
          result_next.position = '0;
        end else if (cell_hit[0]) begin
          state_next           = S_IDLE;
          done_next            = 1'b1;
          result_next.status   = ST_OK;
          result_next.position = 7'(idx + 1'b1);
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      idx   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      idx   <= idx_next;
      done  <= done_next;
    end
  end

  // Result beat register.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // The queue never holds more than its depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  // A scan never runs past the occupied cells.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx <= count)
    else $error("search scan past occupancy");

  // Every accepted request either answers next cycle or starts a scan.
  a_accept_answer: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done != busy))
    else $error("request neither answered nor scanning");

  // A result beat only comes from a request or the end of a scan.
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(accept) || $past(busy)) && !busy)
    else $error("result beat without cause");

  // Occupancy changes only on an accepted enqueue or dequeue.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(accept) |-> $stable(count))
    else $error("entry count changed without request");

endmodule

>>> verif/tb_searchable_fifo_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_searchable_fifo_queue_top: self-checking bench for the searchable FIFO
// An opening table of operations covers the reset state, extreme words,
// duplicate keys, refused dequeues and unused command codes. Random bursts
// then fill, drain, mix and deep-search the queue. A shadow queue predicts
// the result beats not typed in the table, and each done strobe is compared field by field.
// ----------------------------------------------------------------------------
module tb_searchable_fifo_queue_top;
  import sfq_pkg::*;

  localparam int          QDEPTH      = DEPTH_DEF;
  localparam int          RANDOM_OPS  = 1250;
  localparam int          OPENING_LEN = 25;
  localparam int          TIMEOUT_NS  = 5_000_000;
  localparam int          MAX_PRINTS  = 40;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  typedef enum int {BURST_FILL, BURST_DRAIN, BURST_MIXED, BURST_DEEP_SEARCH} burst_kind_t;

  // One row of the opening table; want is used only when typed is set.
  typedef struct {
    logic [1:0]  command;
    logic [31:0] value;
    bit          typed;
    sfq_res_t    want;
  } opening_op_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  sfq_req_t req;
  logic     done;
  sfq_res_t result;

  logic [31:0] shadow_words[$];
  sfq_res_t    pending_results[$];
  opening_op_t opening_ops[OPENING_LEN];
  int          mismatches;
  int          beats_seen;
  int          random_ops;

  searchable_fifo_queue_top #(
    .DEPTH      (QDEPTH),
    .DATA_WIDTH (DATA_WIDTH_DEF)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .req    (req),
    .done   (done),
    .result (result)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("FAIL");
    $finish;
  end

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Applies one operation to the shadow queue and returns the result it gives.
  function automatic sfq_res_t predict_queue_op(input sfq_req_t op);
    sfq_res_t res;
    bit       found;
    res   = '0;
    found = 1'b0;
    case (op.command)
      CMD_ENQUEUE: begin
        if (shadow_words.size() >= QDEPTH) res.status = ST_FULL;
        else shadow_words.push_back(op.value);
      end
      CMD_DEQUEUE: begin
        if (shadow_words.size() == 0) res.status = ST_EMPTY;
        else res.data_out = shadow_words.pop_front();
      end
      CMD_SEARCH: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < shadow_words.size(); i++) begin
          if (!found && shadow_words[i] == op.value) begin
            found        = 1'b1;
            res.position = 7'(i + 1);
            res.status   = ST_OK;
          end
        end
      end
      default: ;
    endcase
    res.occupancy = 7'(shadow_words.size());
    return res;
  endfunction

  function automatic opening_op_t opening_row(input logic [1:0] command,
                                              input logic [31:0] value,
                                              input bit typed,
                                              input sfq_res_t want);
    opening_op_t row;
    row.command = command;
    row.value   = value;
    row.typed   = typed;
    row.want    = want;
    return row;
  endfunction

  // Data word mix: full random, a small pool that makes duplicates, corners.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 3))
      0: return 32'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32'h0000_0000;
          1:       return 32'hFFFF_FFFF;
          2:       return 32'h8000_0000;
          default: return 32'h7FFF_FFFF;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Search keys are mostly words held in the queue, sometimes anything.
  function automatic logic [31:0] pick_key();
    if (shadow_words.size() != 0 && $urandom_range(0, 99) < 80) begin
      return shadow_words[$urandom_range(0, shadow_words.size() - 1)];
    end
    return pick_word();
  endfunction

  // Presents one beat, waits for it to be taken and queues its result.
  task automatic issue_beat(input sfq_req_t beat, input bit use_typed,
                            input sfq_res_t typed_res);
    sfq_res_t predicted;
    int       idle_pct;
    idle_pct = (random_ops >= 500 && random_ops < 800) ? 0 : 20;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    req   <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = predict_queue_op(beat);
    pending_results.push_back(use_typed ? typed_res : predicted);
  endtask

  // Random operation checked against the predictor; ignored codes not counted.
  task automatic issue_op(input logic [1:0] command, input logic [31:0] value);
    sfq_req_t beat;
    beat.command = command;
    beat.value   = value;
    issue_beat(beat, 1'b0, '0);
    if (command != CMD_UNUSED) random_ops++;
  endtask

  // Result checking: every done strobe is matched with the oldest expectation.
  always @(posedge clk) begin : result_check
    sfq_res_t want;
    if (!rst && done) begin
      beats_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("beat %0d arrived with nothing expected", beats_seen));
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status)
          report_mismatch($sformatf("beat %0d status got %0d want %0d",
                                    beats_seen, result.status, want.status));
        if (result.data_out !== want.data_out)
          report_mismatch($sformatf("beat %0d data_out got %08h want %08h",
                                    beats_seen, result.data_out, want.data_out));
        if (result.position !== want.position)
          report_mismatch($sformatf("beat %0d position got %0d want %0d",
                                    beats_seen, result.position, want.position));
        if (result.occupancy !== want.occupancy)
          report_mismatch($sformatf("beat %0d occupancy got %0d want %0d",
                                    beats_seen, result.occupancy, want.occupancy));
      end
    end
  end

  // Stimulus: reset, opening table, random bursts, drain and verdict.
  initial begin
    burst_kind_t kind;
    int          len;
    int          roll;
    sfq_req_t    beat;

    rst        = 1'b1;
    start      = 1'b0;
    req        = '0;
    mismatches = 0;
    beats_seen = 0;
    random_ops = 0;

    // Opening table: typed results where they are obvious, else predicted.
    opening_ops[0]  = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b1,
                                  {ST_EMPTY, 32'h0, 7'd0, 7'd0});
    opening_ops[1]  = opening_row(CMD_SEARCH, 32'h0000_0000, 1'b1,
                                  {ST_NOT_FOUND, 32'h0, 7'd0, 7'd0});
    opening_ops[2]  = opening_row(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1,
                                  {ST_OK, 32'h0, 7'd0, 7'd0});
    opening_ops[3]  = opening_row(CMD_ENQUEUE, 32'h0000_0000, 1'b1,
                                  {ST_OK, 32'h0, 7'd0, 7'd1});
    opening_ops[4]  = opening_row(CMD_ENQUEUE, 32'hFFFF_FFFF, 1'b1,
                                  {ST_OK, 32'h0, 7'd0, 7'd2});
    opening_ops[5]  = opening_row(CMD_ENQUEUE, 32'h8000_0000, 1'b0, '0);
    opening_ops[6]  = opening_row(CMD_ENQUEUE, 32'hFFFF_FFFF, 1'b0, '0);
    opening_ops[7]  = opening_row(CMD_SEARCH, 32'hFFFF_FFFF, 1'b1,
                                  {ST_OK, 32'h0, 7'd2, 7'd4});
    opening_ops[8]  = opening_row(CMD_SEARCH, 32'h0000_0000, 1'b1,
                                  {ST_OK, 32'h0, 7'd1, 7'd4});
    opening_ops[9]  = opening_row(CMD_SEARCH, 32'h8000_0000, 1'b0, '0);
    opening_ops[10] = opening_row(CMD_SEARCH, 32'h1234_5678, 1'b1,
                                  {ST_NOT_FOUND, 32'h0, 7'd0, 7'd4});
    opening_ops[11] = opening_row(CMD_UNUSED, 32'h0000_0000, 1'b1,
                                  {ST_OK, 32'h0, 7'd0, 7'd4});
    opening_ops[12] = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b1,
                                  {ST_OK, 32'h0, 7'd0, 7'd3});
    opening_ops[13] = opening_row(CMD_SEARCH, 32'hFFFF_FFFF, 1'b0, '0);
    opening_ops[14] = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b1,
                                  {ST_OK, 32'hFFFF_FFFF, 7'd0, 7'd2});
    opening_ops[15] = opening_row(CMD_DEQUEUE, 32'hFFFF_FFFF, 1'b0, '0);
    opening_ops[16] = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b0, '0);
    opening_ops[17] = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b1,
                                  {ST_EMPTY, 32'h0, 7'd0, 7'd0});
    opening_ops[18] = opening_row(CMD_SEARCH, 32'hFFFF_FFFF, 1'b1,
                                  {ST_NOT_FOUND, 32'h0, 7'd0, 7'd0});
    opening_ops[19] = opening_row(CMD_ENQUEUE, 32'h5555_5555, 1'b0, '0);
    opening_ops[20] = opening_row(CMD_ENQUEUE, 32'hAAAA_AAAA, 1'b0, '0);
    opening_ops[21] = opening_row(CMD_SEARCH, 32'hAAAA_AAAA, 1'b0, '0);
    opening_ops[22] = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b0, '0);
    opening_ops[23] = opening_row(CMD_SEARCH, 32'h5555_5555, 1'b0, '0);
    opening_ops[24] = opening_row(CMD_DEQUEUE, 32'h0000_0000, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_ops[i]) begin
      beat.command = opening_ops[i].command;
      beat.value   = opening_ops[i].value;
      issue_beat(beat, opening_ops[i].typed, opening_ops[i].want);
    end

    // Random bursts; the first one is a fill burst so that full refusal is tried early.
    kind = BURST_FILL;
    while (random_ops < RANDOM_OPS) begin
      case (kind)
        BURST_FILL: begin
          len = QDEPTH - shadow_words.size() + $urandom_range(1, 3);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) issue_op(CMD_SEARCH, pick_key());
            else issue_op(CMD_ENQUEUE, pick_word());
          end
        end
        BURST_DRAIN: begin
          len = shadow_words.size() + $urandom_range(1, 3);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) issue_op(CMD_SEARCH, pick_key());
            else issue_op(CMD_DEQUEUE, $urandom());
          end
        end
        BURST_DEEP_SEARCH: begin
          len = $urandom_range(4, 10);
          for (int i = 0; i < len; i++) begin
            if (shadow_words.size() != 0 && $urandom_range(0, 9) < 7)
              issue_op(CMD_SEARCH, shadow_words[shadow_words.size() - 1]);
            else
              issue_op(CMD_SEARCH, pick_key());
          end
        end
        default: begin
          len = $urandom_range(10, 40);
          for (int i = 0; i < len; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 35)      issue_op(CMD_ENQUEUE, pick_word());
            else if (roll < 65) issue_op(CMD_DEQUEUE, $urandom());
            else if (roll < 95) issue_op(CMD_SEARCH, pick_key());
            else                issue_op(CMD_UNUSED, $urandom());
          end
        end
      endcase
      roll = $urandom_range(0, 9);
      if (roll < 2)      kind = BURST_FILL;
      else if (roll < 4) kind = BURST_DRAIN;
      else if (roll < 9) kind = BURST_MIXED;
      else               kind = BURST_DEEP_SEARCH;
    end

    // Drain: wait for every result, then wait on for stray beats.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2 * QDEPTH + 8) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
